// File: rtl/mrd_pkg.sv
`timescale 1ns / 1ps
package mrd_pkg;

  localparam int BP_TAPS = 30;
  localparam int LP_TAPS = 33;
  localparam int ACC_W = 40;
  localparam int SUM_W = 34;
  localparam int SQ_W = 48;

  localparam logic signed [ACC_W-1:0] ACC_BIAS = 40'sd16384;

  localparam logic [1:0] REG_TRAINING_COUNT = 2'd0;
  localparam logic [1:0] REG_SD_MULTIPLIER  = 2'd1;
  localparam logic [1:0] REG_HISTORY_LEN    = 2'd2;

  localparam logic [15:0] TRAINING_COUNT_RESET = 16'd1024;
  localparam logic [3:0]  SD_MULTIPLIER_RESET  = 4'd3;
  localparam logic [5:0]  HISTORY_LEN_RESET    = 6'd8;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        channel;
    logic signed [15:0] sample;
  } req_in_t;

  typedef struct packed {
    logic               detected;
    logic               trained;
    logic signed [15:0] envelope;
    logic [4:0]         active_channels;
    logic signed [15:0] threshold_value;
  } req_out_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
    logic [15:0]             n;
    logic [3:0]              mult;
  } stat_req_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIR, S_DRAIN, S_DECIDE, S_SQ, S_START, S_STAT, S_HIST, S_COUNT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MEAN, ST_PROD, ST_VAR, ST_ROOT, ST_DONE
  } stat_state_t;

  localparam logic signed [15:0] BP_COEF [BP_TAPS] = '{
    16'sd228, 16'sd227, 16'sd200, 16'sd62, -16'sd268, -16'sd810, -16'sd1471, -16'sd2052,
    -16'sd2296, -16'sd1988, -16'sd1051, 16'sd395, 16'sd2043, 16'sd3479, 16'sd4314,
    16'sd4314, 16'sd3479, 16'sd2043, 16'sd395, -16'sd1051, -16'sd1988, -16'sd2296,
    -16'sd2052, -16'sd1471, -16'sd810, -16'sd268, 16'sd62, 16'sd200, 16'sd227, 16'sd228
  };

  localparam logic signed [15:0] LP_COEF [LP_TAPS] = '{
    16'sd668, 16'sd356, 16'sd442, 16'sd536, 16'sd634, 16'sd736, 16'sd840, 16'sd944,
    16'sd1044, 16'sd1139, 16'sd1228, 16'sd1306, 16'sd1374, 16'sd1428, 16'sd1468,
    16'sd1492, 16'sd1500, 16'sd1492, 16'sd1468, 16'sd1428, 16'sd1374, 16'sd1306,
    16'sd1228, 16'sd1139, 16'sd1044, 16'sd944, 16'sd840, 16'sd736, 16'sd634, 16'sd536,
    16'sd442, 16'sd356, 16'sd668
  };

  function automatic logic signed [15:0] tap_coef(input logic lp, input logic [5:0] k);
    logic signed [15:0] c;
    c = 16'sd0;
    if (lp) begin
      if (k < 6'(LP_TAPS)) c = LP_COEF[k];
    end else begin
      if (k < 6'(BP_TAPS)) c = BP_COEF[k[4:0]];
    end
    return c;
  endfunction

endpackage

// File: rtl/mrd_ram.sv
`timescale 1ns / 1ps
module mrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mrd_stats.sv
`timescale 1ns / 1ps
module mrd_stats import mrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  stat_req_t          req,
  output logic               done,
  output logic signed [15:0] thr
);

  stat_state_t st, st_next;
  logic [5:0]       step;
  logic             neg;
  logic [SUM_W-1:0] smag;
  logic [47:0]      quo;
  logic [15:0]      rem;
  logic [15:0]      n;
  logic [3:0]       mult;
  logic [SQ_W-1:0]  sqr;
  logic [15:0]      mq;
  logic [49:0]      pacc, pb;
  logic [15:0]      pq;
  logic [47:0]      v, r, bitm;

  logic [16:0]      rem_s, rem_d;
  logic             div_ge;
  logic [47:0]      quo_d;
  logic [49:0]      pacc_d, sq_ext, diff;
  logic [47:0]      dev;
  logic [47:0]      rb;
  logic             root_ge;
  logic [SUM_W-1:0] sum_abs;
  logic signed [16:0] mean;
  logic [27:0]      prodm;
  logic signed [29:0] t;

  always_comb begin
    rem_s   = {rem, quo[47]};
    div_ge  = rem_s >= {1'b0, n};
    rem_d   = div_ge ? rem_s - {1'b0, n} : rem_s;
    quo_d   = {quo[46:0], div_ge};
    pacc_d  = pq[0] ? pacc + pb : pacc;
    sq_ext  = {2'b00, sqr};
    diff    = sq_ext - pacc_d;
    dev     = (pacc_d > sq_ext) ? 48'd0 : diff[47:0];
    rb      = r + bitm;
    root_ge = v >= rb;
    sum_abs = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
    mean    = neg ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
    prodm   = mult * r[23:0];
    t       = 30'(mean) + $signed({2'b00, prodm});
    if (t > 30'sd32767) thr = 16'sd32767;
    else if (t < -30'sd32768) thr = -16'sd32768;
    else thr = t[15:0];
    done = (st == ST_DONE);
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (req.start) st_next = ST_MEAN;
      ST_MEAN: if (step == 6'd47) st_next = ST_PROD;
      ST_PROD: if (step == 6'd15) st_next = ST_VAR;
      ST_VAR:  if (step == 6'd47) st_next = ST_ROOT;
      ST_ROOT: if (step == 6'd23) st_next = ST_DONE;
      ST_DONE: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    step <= (st_next != st) ? 6'd0 : step + 6'd1;
    unique case (st)
      ST_IDLE: begin
        if (req.start) begin
          neg  <= req.sum[SUM_W-1];
          smag <= sum_abs;
          quo  <= {{(48-SUM_W){1'b0}}, sum_abs};
          rem  <= 16'd0;
          n    <= req.n;
          mult <= req.mult;
          sqr  <= req.sq;
        end
      end
      ST_MEAN: begin
        quo <= quo_d;
        rem <= rem_d[15:0];
        if (step == 6'd47) begin
          mq   <= quo_d[15:0];
          pq   <= quo_d[15:0];
          pacc <= 50'd0;
          pb   <= {{(50-SUM_W){1'b0}}, smag} + {34'd0, rem_d[15:0]};
        end
      end
      ST_PROD: begin
        pacc <= pacc_d;
        pb   <= {pb[48:0], 1'b0};
        pq   <= {1'b0, pq[15:1]};
        if (step == 6'd15) begin
          quo <= dev;
          rem <= 16'd0;
        end
      end
      ST_VAR: begin
        quo <= quo_d;
        rem <= rem_d[15:0];
        if (step == 6'd47) begin
          v    <= quo_d;
          r    <= 48'd0;
          bitm <= 48'd1 << 46;
        end
      end
      ST_ROOT: begin
        if (root_ge) begin
          v <= v - rb;
          r <= {1'b0, r[47:1]} + bitm;
        end else begin
          r <= {1'b0, r[47:1]};
        end
        bitm <= {2'b00, bitm[47:2]};
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

// File: rtl/multichannel_ripple_detector.sv
`timescale 1ns / 1ps
// Multichannel ripple detector.
// Requests enter on src (src_valid/src_stall, payload src_req) and one result
// per request leaves on dst (dst_valid/dst_stall, payload dst_req). A request
// is taken when valid is high and stall is low at a rising edge.
// A sample request runs 30 bandpass and 33 lowpass taps through one shared
// multiplier fed by the delay-line memory, one tap a cycle, with a pipeline
// drain after each filter, then a sweep over the detection histories of all
// channels. The next request is taken only after the result has gone to the
// output register. The request that ends a channel's training also runs the
// iterative mean, variance divide and square root before the sweep.
// A clear request (cmd 1) and reset both start a clearing pass over the delay
// memories of all channels during which src is stalled; configuration writes
// are taken at any time. A clear request then returns an all-zero result.
// The result sits in an output register; a stalled dst holds it while the
// next request is already processed, which then waits until dst is free.
module multichannel_ripple_detector import mrd_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int HISTORY_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  req_in_t     src_req,
  output logic        dst_valid,
  input  logic        dst_stall,
  output req_out_t    dst_req,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACTW = $clog2(CHANNELS + 1);
  localparam int CLR_W = CW + 6;
  localparam int BP_DEPTH = (1 << CW) * 32;
  localparam int LP_DEPTH = (1 << CW) * 64;

  state_t state, state_next;

  logic [15:0] training_count;
  logic [3:0]  sd_multiplier;
  logic [5:0]  history_len;

  logic [4:0]              bp_pos   [CHANNELS];
  logic [5:0]              lp_pos   [CHANNELS];
  logic [15:0]             seen     [CHANNELS];
  logic signed [SUM_W-1:0] sum_r    [CHANNELS];
  logic [SQ_W-1:0]         sq_r     [CHANNELS];
  logic signed [15:0]      thr_r    [CHANNELS];
  logic                    trained_r[CHANNELS];
  logic [HISTORY_MAX-1:0]  hist     [CHANNELS];

  req_in_t            req;
  logic [7:0]         ch_wide, src_ch_wide;
  logic [CW-1:0]      ch, src_ch;
  logic               in_range;
  logic               fsel;
  logic [5:0]         k, ridx, k1, taps_last;
  logic               v1, v2;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0] opnd, env, mid, ab;
  logic signed [15:0] mul_a, mul_b;
  logic               det, trn_o;
  logic signed [15:0] thr_o;
  logic [CLR_W-1:0]   clr;
  logic               clr_reply;
  logic [CW-1:0]      cnt_i;
  logic [ACTW-1:0]    act;
  logic [15:0]        need;
  logic [HISTORY_MAX-1:0] win;
  logic [6:0]         hl;
  logic [HISTORY_MAX:0]   hshift;
  logic [4:0]         op_out_act;

  logic                bp_we, lp_we, clearing;
  logic [CW+4:0]       bp_waddr, bp_raddr;
  logic [CW+5:0]       lp_waddr, lp_raddr;
  logic [15:0]         bp_wdata, lp_wdata, bp_rdata, lp_rdata;

  stat_req_t          st_req;
  logic               st_done;
  logic signed [15:0] st_thr;

  assign ch_wide     = {4'd0, req.channel};
  assign src_ch_wide = {4'd0, src_req.channel};
  assign ch          = ch_wide[CW-1:0];
  assign src_ch      = src_ch_wide[CW-1:0];
  assign in_range    = ch_wide < 8'(CHANNELS);
  assign taps_last   = fsel ? 6'(LP_TAPS - 1) : 6'(BP_TAPS - 1);
  assign need        = (training_count == 16'd0) ? 16'd1 : training_count;
  assign mid         = acc[30:15];
  assign ab          = (mid == -16'sd32768) ? 16'sd32767 : (mid < 0 ? -mid : mid);
  assign clearing    = (state == S_CLEAR);
  assign hl          = ({1'b0, history_len} > 7'(HISTORY_MAX)) ? 7'(HISTORY_MAX)
                                                              : {1'b0, history_len};
  assign hshift      = {hist[ch], det};
  assign op_out_act  = 5'(act);

  always_comb begin
    for (int i = 0; i < HISTORY_MAX; i++) win[i] = (7'(i) < hl);
  end

  always_comb begin
    bp_we    = clearing || (state == S_FIR && k == 6'd0 && !fsel);
    lp_we    = clearing || (state == S_FIR && k == 6'd0 && fsel);
    bp_wdata = clearing ? 16'd0 : opnd;
    lp_wdata = clearing ? 16'd0 : opnd;
    bp_waddr = clearing ? {clr[CLR_W-1:6], clr[4:0]} : {ch, bp_pos[ch]};
    lp_waddr = clearing ? clr : {ch, lp_pos[ch]};
    bp_raddr = {ch, ridx[4:0]};
    lp_raddr = {ch, ridx};
    if (state == S_DECIDE) begin
      mul_a = env;
      mul_b = env;
    end else begin
      mul_a = (k1 == 6'd0) ? opnd : (fsel ? lp_rdata : bp_rdata);
      mul_b = tap_coef(fsel, k1);
    end
    st_req.start = (state == S_START);
    st_req.sum   = sum_r[ch];
    st_req.sq    = sq_r[ch];
    st_req.n     = seen[ch];
    st_req.mult  = sd_multiplier;
  end

  always_comb begin
    state_next = state;
    src_stall  = (state != S_IDLE);
    unique case (state)
      S_CLEAR:  if (clr == CLR_W'(CHANNELS * 64 - 1)) state_next = clr_reply ? S_OUT : S_IDLE;
      S_IDLE: begin
        if (src_valid) begin
          if (src_req.cmd) state_next = S_CLEAR;
          else if (src_ch_wide < 8'(CHANNELS)) state_next = S_FIR;
          else state_next = S_HIST;
        end
      end
      S_FIR:    if (k == taps_last) state_next = S_DRAIN;
      S_DRAIN:  if (!v1 && !v2) state_next = fsel ? S_DECIDE : S_FIR;
      S_DECIDE: state_next = trained_r[ch] ? S_HIST : S_SQ;
      S_SQ:     state_next = (seen[ch] >= need) ? S_START : S_HIST;
      S_START:  state_next = S_STAT;
      S_STAT:   if (st_done) state_next = S_HIST;
      S_HIST:   state_next = S_COUNT;
      S_COUNT:  if (cnt_i == CW'(CHANNELS - 1)) state_next = S_OUT;
      S_OUT:    if (!dst_valid || !dst_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      training_count <= TRAINING_COUNT_RESET;
      sd_multiplier  <= SD_MULTIPLIER_RESET;
      history_len    <= HISTORY_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRAINING_COUNT: training_count <= cfg_data;
        REG_SD_MULTIPLIER:  sd_multiplier  <= cfg_data[3:0];
        REG_HISTORY_LEN:    history_len    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // tap pipeline: issue read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_FIR);
      v2 <= v1;
    end
    k1   <= k;
    prod <= mul_a * mul_b;
    if (v2) acc <= acc + ACC_W'(prod);
    else if ((state == S_IDLE && src_valid) || (state == S_DRAIN && !v1 && !v2 && !fsel))
      acc <= ACC_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      clr_reply <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        bp_pos[i] <= '0; lp_pos[i] <= '0; seen[i] <= '0; sum_r[i] <= '0;
        sq_r[i] <= '0; thr_r[i] <= '0; trained_r[i] <= 1'b0; hist[i] <= '0;
      end
    end else begin
      unique case (state)
        S_CLEAR: clr <= clr + CLR_W'(1);
        S_IDLE: begin
          if (src_valid) begin
            req   <= src_req;
            opnd  <= src_req.sample;
            fsel  <= 1'b0;
            k     <= 6'd0;
            ridx  <= (src_ch_wide < 8'(CHANNELS)) ? {1'b0, bp_pos[src_ch]} : 6'd0;
            env   <= 16'sd0;
            det   <= 1'b0;
            trn_o <= 1'b0;
            thr_o <= 16'sd0;
            act   <= '0;
            if (src_req.cmd) begin
              clr       <= '0;
              clr_reply <= 1'b1;
              for (int i = 0; i < CHANNELS; i++) begin
                bp_pos[i] <= '0; lp_pos[i] <= '0; seen[i] <= '0; sum_r[i] <= '0;
                sq_r[i] <= '0; thr_r[i] <= '0; trained_r[i] <= 1'b0; hist[i] <= '0;
              end
            end
          end
        end
        S_FIR: begin
          k    <= k + 6'd1;
          ridx <= (ridx == 6'd0) ? taps_last : ridx - 6'd1;
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            k <= 6'd0;
            if (!fsel) begin
              opnd       <= ab;
              fsel       <= 1'b1;
              ridx       <= lp_pos[ch];
              bp_pos[ch] <= (bp_pos[ch] == 5'(BP_TAPS - 1)) ? 5'd0 : bp_pos[ch] + 5'd1;
            end else begin
              env        <= mid;
              lp_pos[ch] <= (lp_pos[ch] == 6'(LP_TAPS - 1)) ? 6'd0 : lp_pos[ch] + 6'd1;
            end
          end
        end
        S_DECIDE: begin
          if (trained_r[ch]) begin
            det <= (env >= thr_r[ch]);
          end else begin
            sum_r[ch] <= sum_r[ch] + SUM_W'(env);
            seen[ch]  <= seen[ch] + 16'd1;
          end
        end
        S_SQ: sq_r[ch] <= sq_r[ch] + {{(SQ_W-32){1'b0}}, prod};
        S_START: ;
        S_STAT: begin
          if (st_done) begin
            thr_r[ch]     <= st_thr;
            trained_r[ch] <= 1'b1;
          end
        end
        S_HIST: begin
          cnt_i <= '0;
          act   <= '0;
          if (in_range) begin
            hist[ch] <= hshift[HISTORY_MAX-1:0];
            trn_o    <= trained_r[ch];
            thr_o    <= thr_r[ch];
          end
        end
        S_COUNT: begin
          act   <= act + ACTW'(|(hist[cnt_i] & win));
          cnt_i <= cnt_i + CW'(1);
        end
        S_OUT: if (!dst_valid || !dst_stall) clr_reply <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (state == S_OUT && (!dst_valid || !dst_stall)) begin
      dst_valid <= 1'b1;
      dst_req.detected        <= det;
      dst_req.trained         <= trn_o;
      dst_req.envelope        <= env;
      dst_req.active_channels <= op_out_act;
      dst_req.threshold_value <= thr_o;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  mrd_ram #(.WIDTH(16), .DEPTH(BP_DEPTH)) u_bp_ram (
    .clk(clk), .we(bp_we), .waddr(bp_waddr), .wdata(bp_wdata),
    .raddr(bp_raddr), .rdata(bp_rdata)
  );

  mrd_ram #(.WIDTH(16), .DEPTH(LP_DEPTH)) u_lp_ram (
    .clk(clk), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
    .raddr(lp_raddr), .rdata(lp_rdata)
  );

  mrd_stats u_stats (
    .clk(clk), .rst(rst), .req(st_req), .done(st_done), .thr(st_thr)
  );

  a_stat_done: assert property (@(posedge clk) disable iff (rst)
    st_done |-> state == S_STAT) else $error("stats done outside wait state");

  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> !v1 && !v2) else $error("tap pipeline busy at decision");

  a_act_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> act <= ACTW'(CHANNELS)) else $error("active count overflow");

endmodule
